// ===== hw/rtl/deq_pkg.sv =====
`default_nettype none

package deq_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned WORD_W = 32;
    localparam int unsigned OCC_W  = 8;

    // Operation codes carried by an input transaction.
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } op_t;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Command broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CMD_HOLD        = 3'd0,
        CMD_SHIFT_RIGHT = 3'd1,
        CMD_SHIFT_LEFT  = 3'd2,
        CMD_WRITE_REAR  = 3'd3,
        CMD_CLEAR_REAR  = 3'd4
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t          cmd;
        logic [WORD_W-1:0]  value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
// Channel   Direction   Handshake              Payload
// input     in          in_valid / in_stall    operation, push_value
// output    out         out_valid / out_stall  pop_value, status, occupancy
//
// Push front, push rear and pop front are applied at once, so a new transaction
// can be taken on every cycle unless a result is held behind out_stall. Pop rear
// on a non-empty deque waits for the registered OR tree that fetches the rear cell's word.
// Reset clears the control state and every cell's occupied flag; no clearing pass.
// While a result waits under out_stall, one more transaction is executed and its
// result is held until the output register frees up.

`default_nettype none

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = 128
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [1:0]               operation,
    input  wire logic signed [WORD_W-1:0] push_value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [WORD_W-1:0]      pop_value,
    output logic [1:0]                    status,
    output logic [OCC_W-1:0]              occupancy
);

    localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
    localparam int unsigned TREE_LAT = $clog2(DEPTH) / 2;
    localparam int unsigned WAIT_W   = (TREE_LAT > 1) ? $clog2(TREE_LAT) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_TREE = 3'b010,
        S_HOLD = 3'b100
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [WAIT_W-1:0]   wait_reg;
    logic [WAIT_W-1:0]   wait_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [WORD_W-1:0]   out_value_reg;
    status_t             out_status_reg;
    logic [OCC_W-1:0]    out_occ_reg;
    logic [WORD_W-1:0]   hold_value_reg;
    status_t             hold_status_reg;
    logic [OCC_W-1:0]    hold_occ_reg;

    logic                accept;
    logic                out_free;
    logic                apply;
    op_t                 cur_op;
    logic                full;
    logic                empty;
    logic [WORD_W-1:0]   res_value;
    status_t             res_status;
    cell_ctrl_t          ctrl;
    logic                load_out;
    logic                load_hold;
    logic                load_from_hold;

    logic [WORD_W-1:0]   cell_data [DEPTH];
    logic                cell_occ  [DEPTH];
    logic [WORD_W-1:0]   cell_tap  [DEPTH];
    logic [WORD_W-1:0]   rear_word;

    // Handshake on both sides.
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // A pop rear on a non-empty deque waits for the tree; all else runs at once.
    always_comb
    begin
        cur_op = op_t'(operation);
        apply  = 1'b0;
        if (state_reg == S_TREE)
        begin
            cur_op = OP_POP_REAR;
            apply  = (wait_reg == '0);
        end
        else if (accept)
        begin
            apply = !((cur_op == OP_POP_REAR) && !empty && (TREE_LAT > 0));
        end
    end

    // Result and chain command for the transaction being applied.
    always_comb
    begin
        res_value  = '0;
        res_status = ST_OK;
        count_next = count_reg;
        ctrl.cmd   = CMD_HOLD;
        ctrl.value = push_value;
        if (apply)
        begin
            unique case (cur_op)
                OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        ctrl.cmd   = CMD_SHIFT_RIGHT;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_PUSH_REAR:
                begin
                    if (full)
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        ctrl.cmd   = CMD_WRITE_REAR;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        res_status = ST_EMPTY;
                    end
                    else
                    begin
                        res_value  = cell_data[0];
                        ctrl.cmd   = CMD_SHIFT_LEFT;
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_POP_REAR:
                begin
                    if (empty)
                    begin
                        res_status = ST_EMPTY;
                    end
                    else
                    begin
                        res_value  = rear_word;
                        ctrl.cmd   = CMD_CLEAR_REAR;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sequencing: tree wait, holding a result behind a stalled output.
    always_comb
    begin
        state_next     = state_reg;
        wait_next      = wait_reg;
        load_out       = 1'b0;
        load_hold      = 1'b0;
        load_from_hold = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !apply)
                begin
                    state_next = S_TREE;
                    wait_next  = WAIT_W'(TREE_LAT - 1);
                end
                else if (apply)
                begin
                    load_out  = out_free;
                    load_hold = !out_free;
                    if (!out_free)
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_TREE:
            begin
                if (apply)
                begin
                    load_out   = out_free;
                    load_hold  = !out_free;
                    state_next = out_free ? S_IDLE : S_HOLD;
                end
                else
                begin
                    wait_next = wait_reg - 1'b1;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    load_from_hold = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The output register is refilled or emptied as results come and go.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out || load_from_hold)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_value_reg  <= res_value;
            out_status_reg <= res_status;
            out_occ_reg    <= OCC_W'(count_next);
        end
        else if (load_from_hold)
        begin
            out_value_reg  <= hold_value_reg;
            out_status_reg <= hold_status_reg;
            out_occ_reg    <= hold_occ_reg;
        end
        if (load_hold)
        begin
            hold_value_reg  <= res_value;
            hold_status_reg <= res_status;
            hold_occ_reg    <= OCC_W'(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign pop_value = out_value_reg;
    assign status    = out_status_reg;
    assign occupancy = out_occ_reg;

    // Chain of cells: front at cell 0, rear at the last occupied cell.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_W-1:0] left_data;
        logic              left_occ;
        logic [WORD_W-1:0] right_data;
        logic              right_occ;

        if (i == 0)
        begin : g_front
            assign left_data = ctrl.value;
            assign left_occ  = 1'b1;
        end
        else
        begin : g_inner_left
            assign left_data = cell_data[i-1];
            assign left_occ  = cell_occ[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_back
            assign right_data = '0;
            assign right_occ  = 1'b0;
        end
        else
        begin : g_inner_right
            assign right_data = cell_data[i+1];
            assign right_occ  = cell_occ[i+1];
        end

        deq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .left_data  (left_data),
            .left_occ   (left_occ),
            .right_data (right_data),
            .right_occ  (right_occ),
            .data       (cell_data[i]),
            .occ        (cell_occ[i]),
            .tap        (cell_tap[i])
        );
    end

    // Registered OR tree that brings the rear word to the controller.
    deq_rear_tree #(
        .DEPTH (DEPTH)
    ) u_rear_tree (
        .clk       (clk),
        .taps      (cell_tap),
        .rear_word (rear_word)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/deq_cell.sv =====
`default_nettype none

module deq_cell
    import deq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [WORD_W-1:0] left_data,
    input  wire logic              left_occ,
    input  wire logic [WORD_W-1:0] right_data,
    input  wire logic              right_occ,
    output logic [WORD_W-1:0]      data,
    output logic                   occ,
    output logic [WORD_W-1:0]      tap
);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic              occ_reg;
    logic              occ_next;
    logic              is_last;
    logic              is_slot;

    // This cell holds the rear word, or is the first free cell after it.
    assign is_last = occ_reg && !right_occ;
    assign is_slot = !occ_reg && left_occ;

    // Next contents follow the command shared by the whole chain.
    always_comb
    begin
        data_next = data_reg;
        occ_next  = occ_reg;
        unique case (ctrl.cmd)
            CMD_HOLD:
            begin
            end
            CMD_SHIFT_RIGHT:
            begin
                data_next = left_data;
                occ_next  = left_occ;
            end
            CMD_SHIFT_LEFT:
            begin
                data_next = right_data;
                occ_next  = right_occ;
            end
            CMD_WRITE_REAR:
            begin
                if (is_slot)
                begin
                    data_next = ctrl.value;
                    occ_next  = 1'b1;
                end
            end
            CMD_CLEAR_REAR:
            begin
                if (is_last)
                begin
                    occ_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // The occupied flag is control state and is cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // The word itself needs no reset: it is only read once occupied.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign occ  = occ_reg;
    assign tap  = is_last ? data_reg : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/deq_rear_tree.sv =====
`default_nettype none

module deq_rear_tree
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = 128
)
(
    input  wire logic              clk,
    input  wire logic [WORD_W-1:0] taps [DEPTH],
    output logic [WORD_W-1:0]      rear_word
);

    localparam int unsigned LEVELS = $clog2(DEPTH);
    localparam int unsigned LEAVES = 1 << LEVELS;

    // Heap-ordered OR tree: node 1 is the root, leaves start at LEAVES.
    logic [WORD_W-1:0] node [1:2*LEAVES-1];

    // Leaves take the cell taps; padding leaves are zero.
    for (genvar i = 0; i < LEAVES; i++)
    begin : g_leaf
        if (i < DEPTH)
        begin : g_tap
            assign node[LEAVES+i] = taps[i];
        end
        else
        begin : g_pad
            assign node[LEAVES+i] = '0;
        end
    end

    // Only the rear cell drives a nonzero tap, so OR-ing picks it out.
    // Every second level counted from the leaves is registered.
    for (genvar n = 1; n < LEAVES; n++)
    begin : g_node
        localparam int unsigned LVL = $clog2(n + 1) - 1;
        if (((LEVELS - LVL) % 2) == 0)
        begin : g_reg
            always_ff @(posedge clk)
            begin
                node[n] <= node[2*n] | node[2*n+1];
            end
        end
        else
        begin : g_comb
            assign node[n] = node[2*n] | node[2*n+1];
        end
    end

    assign rear_word = node[1];

endmodule

`default_nettype wire

// ===== hw/rtl/deq_checker.sv =====
`default_nettype none

module deq_checker
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = 128
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     out_valid,
    input  wire logic                     out_stall,
    input  wire logic signed [WORD_W-1:0] pop_value,
    input  wire logic [1:0]               status,
    input  wire logic [OCC_W-1:0]         occupancy
);

    // A stalled result transaction stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pop_value)
            && $stable(status) && $stable(occupancy))
    else $error("stalled result transaction changed");

    // A rejected operation never returns a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (pop_value == '0))
    else $error("failed operation returned a nonzero word");

    // A rejected push leaves the deque at its full depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> (occupancy == OCC_W'(DEPTH)))
    else $error("full status with occupancy below depth");

    // A rejected pop leaves the deque empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> (occupancy == '0))
    else $error("empty status with words still held");

endmodule

bind double_ended_queue deq_checker #(
    .DEPTH (DEPTH)
) u_deq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pop_value  (pop_value),
    .status     (status),
    .occupancy  (occupancy)
);

`default_nettype wire

// ===== tb/sv/tb_double_ended_queue.sv =====
`timescale 1ns / 1ps

module tb_double_ended_queue;
    import deq_pkg::*;

    localparam int DEPTH       = 128;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 24;
    localparam int MAX_WAIT    = 16;

    // Expected contents of one result transaction.
    typedef struct {
        logic signed [WORD_W-1:0] word;
        status_t                  st;
        logic [OCC_W-1:0]         occ;
    } deque_result_t;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_stall;
    logic [1:0]               operation  = OP_PUSH_FRONT;
    logic signed [WORD_W-1:0] push_value = '0;
    logic                     out_valid;
    logic                     out_stall  = 1'b0;
    logic signed [WORD_W-1:0] pop_value;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;

    // Shadow copy of the deque contents.
    logic [WORD_W-1:0] shadow_words [DEPTH];
    int                shadow_head  = 0;
    int                shadow_count = 0;

    deque_result_t expected_results[$];
    int            error_count = 0;
    int            cycle_count = 0;
    bit            tx_no_gaps  = 1'b0;
    bit            rx_no_stall = 1'b0;
    int            stall_left  = 0;

    double_ended_queue #(.DEPTH(DEPTH)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pop_value  (pop_value),
        .status     (status),
        .occupancy  (occupancy)
    );

    always #1 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (error_count < 40)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // Applies one operation to the shadow deque and returns the result it yields.
    function automatic deque_result_t deque_apply(input op_t op,
                                                  input logic [WORD_W-1:0] word);
        deque_result_t r;
        r.word = '0;
        r.st   = ST_OK;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR)
        begin
            if (shadow_count >= DEPTH)
                r.st = ST_FULL;
            else if (op == OP_PUSH_FRONT)
            begin
                shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                shadow_words[shadow_head] = word;
                shadow_count++;
            end
            else
            begin
                shadow_words[(shadow_head + shadow_count) % DEPTH] = word;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
                r.st = ST_EMPTY;
            else if (op == OP_POP_FRONT)
            begin
                r.word = shadow_words[shadow_head];
                shadow_head = (shadow_head + 1) % DEPTH;
                shadow_count--;
            end
            else
            begin
                r.word = shadow_words[(shadow_head + shadow_count - 1) % DEPTH];
                shadow_count--;
            end
        end
        r.occ = OCC_W'(shadow_count);
        return r;
    endfunction

    // Sends one input transaction and records its expected result.
    task automatic send_op(input op_t op, input logic [WORD_W-1:0] word);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        push_value <= word;
        expected_results.push_back(deque_apply(op, word));
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Holds the input idle until every pending result has been checked.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Picks an operation with the given chance of a push.
    function automatic op_t pick_op(input int push_pct);
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
        return $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
    endfunction

    // Result checker with random output stalls.
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result transaction with nothing pending");
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("pop_value", pop_value, want.word);
                    compare_field("status", WORD_W'(status), WORD_W'(want.st));
                    compare_field("occupancy", WORD_W'(occupancy), WORD_W'(want.occ));
                end
                stall_left = rx_no_stall ? 0 : $urandom_range(0, MAX_WAIT);
            end
            out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    // Pops on an empty deque from both ends.
    task automatic test_empty_pops();
        send_op(OP_POP_FRONT, 32'h1234_5678);
        send_op(OP_POP_REAR, 32'hFFFF_FFFF);
    endtask

    // Every operation with extreme words, wrapping the head both ways.
    task automatic test_directed_ops();
        send_op(OP_PUSH_FRONT, 32'h7FFF_FFFF);
        send_op(OP_PUSH_REAR, 32'h8000_0000);
        send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF);
        send_op(OP_PUSH_REAR, 32'h0000_0000);
        send_op(OP_PUSH_REAR, 32'h5555_5555);
        send_op(OP_PUSH_FRONT, 32'hAAAA_AAAA);
        send_op(OP_POP_FRONT, '0);
        send_op(OP_POP_REAR, 32'hFFFF_FFFF);
        send_op(OP_POP_REAR, '0);
        send_op(OP_POP_FRONT, '0);
        send_op(OP_POP_FRONT, '0);
        send_op(OP_POP_REAR, '0);
        send_op(OP_POP_REAR, '0);
        send_op(OP_POP_FRONT, '0);
        send_op(OP_PUSH_REAR, 32'h0000_0001);
        send_op(OP_POP_FRONT, '0);
    endtask

    // Fills the deque to capacity, pushes into it while full, drains it, then pops it while empty.
    task automatic test_fill_and_full();
        tx_no_gaps = 1'b1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == DEPTH / 2)
                tx_no_gaps = 1'b0;
            send_op($urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT, $urandom);
        end
        send_op(OP_PUSH_FRONT, $urandom);
        send_op(OP_PUSH_REAR, $urandom);

        // Let the output side empty out before draining.
        wait_results_drained();
        rx_no_stall = 1'b1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == DEPTH / 2)
                rx_no_stall = 1'b0;
            send_op($urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT, $urandom);
        end
        send_op(OP_POP_REAR, $urandom);
        send_op(OP_POP_FRONT, $urandom);
    endtask

    // Random segments that grow, shrink or hold the occupancy level.
    task automatic test_random_mix(input int n_items);
        int sent;
        int seg_len;
        int push_pct;
        sent = 0;
        while (sent < n_items)
        begin
            seg_len     = $urandom_range(8, 60);
            push_pct    = $urandom_range(0, 2) == 0 ? 85 : ($urandom_range(0, 1) ? 50 : 20);
            tx_no_gaps  = ($urandom_range(0, 3) == 0);
            rx_no_stall = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < seg_len && sent < n_items; i++)
            begin
                send_op(pick_op(push_pct), $urandom);
                sent++;
            end
        end
        tx_no_gaps  = 1'b0;
        rx_no_stall = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pops();
        test_directed_ops();
        test_fill_and_full();
        test_random_mix(300);

        // Wait for the last results, then let the pipeline settle.
        wait_results_drained();
        repeat (SETTLE) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("expected results left over at the end");

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
